[design/humidity_sensor_single_wire_reader_macros.svh]
// Assertion macros used by the reader's top-level RTL file
`ifndef HUMIDITY_SENSOR_SINGLE_WIRE_READER_MACROS_SVH
`define HUMIDITY_SENSOR_SINGLE_WIRE_READER_MACROS_SVH

// same-cycle implication
`define HSSWR_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("hsswr check failed");

// next-cycle implication
`define HSSWR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("hsswr check failed");

`endif

[design/hsswr_pkg.sv]
// Types and constants of the single-wire humidity sensor reader
`timescale 1ns / 1ps
package hsswr_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 2'd2;

	localparam logic [19:0] START_LOW_RST     = 20'd20000;
	localparam logic [7:0]  BIT_THRESHOLD_RST = 8'd50;
	localparam logic [23:0] READ_INTERVAL_RST = 24'd2000000;

	localparam logic [5:0] FRAME_BITS = 6'd40;

	typedef enum logic [2:0] {
		PH_INTERVAL,
		PH_START,
		PH_RESP_HIGH,
		PH_RESP_LOW,
		PH_RESP_RISE,
		PH_BIT_WAIT,
		PH_BIT_HIGH
	} phase_t;

	typedef struct packed {
		logic [19:0] start_low;
		logic [7:0]  bit_threshold;
		logic [23:0] read_interval;
	} cfg_t;

	typedef struct packed {
		logic        drive_low;
		logic        frame_valid;
		logic [7:0]  humidity_whole;
		logic [7:0]  humidity_frac;
		logic [7:0]  temperature_whole;
		logic [7:0]  temperature_frac;
		logic [7:0]  received_sum;
		logic        sum_mismatch;
		logic [15:0] mismatch_count;
	} result_t;

endpackage

[design/hsswr_cfg.sv]
// Configuration register file of the reader
`timescale 1ns / 1ps
module hsswr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [hsswr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hsswr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hsswr_pkg::cfg_t                    cfg
);
	import hsswr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low     <= START_LOW_RST;
			cfg_q.bit_threshold <= BIT_THRESHOLD_RST;
			cfg_q.read_interval <= READ_INTERVAL_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_LOW:     cfg_q.start_low     <= cfg_data[19:0];
				REG_BIT_THRESHOLD: cfg_q.bit_threshold <= cfg_data[7:0];
				REG_READ_INTERVAL: cfg_q.read_interval <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/hsswr_core.sv]
// Phase machine, pulse timer and frame assembly of the reader
`timescale 1ns / 1ps
module hsswr_core #(
	parameter int TIMER_WIDTH = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                level,
	input  hsswr_pkg::cfg_t     cfg,
	output hsswr_pkg::result_t  res
);
	import hsswr_pkg::*;

	localparam int CmpW = (TIMER_WIDTH > 24) ? TIMER_WIDTH : 24;
	localparam logic [TIMER_WIDTH-1:0] TMax = {TIMER_WIDTH{1'b1}};

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] tick_q, tick_d, tick_inc;
	logic                   prev_q;
	logic [5:0]             bits_q, bits_d, bits_dec;
	logic [39:0]            shift_q, shift_d, shift_in;
	logic [7:0]             pub_q [5];
	logic [7:0]             pub_d [5];
	logic                   flag_q, flag_d;
	logic [15:0]            total_q, total_d;
	logic                   publish;
	logic                   wait_done, start_done, bit_one, mismatch;
	logic [7:0]             sum;

	always_comb begin
		tick_inc   = (tick_q != TMax) ? tick_q + 1'b1 : tick_q;
		wait_done  = (CmpW'(tick_inc) >= CmpW'(cfg.read_interval)) || (tick_inc == TMax);
		start_done = (CmpW'(tick_inc) >= CmpW'(cfg.start_low)) || (tick_inc == TMax);
		bit_one    = CmpW'(tick_q) > CmpW'(cfg.bit_threshold);
		shift_in   = {shift_q[38:0], bit_one};
		bits_dec   = (bits_q != 6'd0) ? bits_q - 6'd1 : bits_q;
		sum        = shift_in[39:32] + shift_in[31:24] + shift_in[23:16] + shift_in[15:8];
		mismatch   = sum != shift_in[7:0];
	end

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		publish = 1'b0;
		unique case (phase_q)
			PH_INTERVAL: begin
				tick_d = tick_inc;
				if (wait_done) begin
					phase_d = PH_START;
					tick_d  = '0;
				end
			end
			PH_START: begin
				tick_d = tick_inc;
				if (start_done) begin
					phase_d = PH_RESP_HIGH;
					tick_d  = '0;
				end
			end
			PH_RESP_HIGH: if (level) phase_d = PH_RESP_LOW;
			PH_RESP_LOW:  if (!level) phase_d = PH_RESP_RISE;
			PH_RESP_RISE: if (level) phase_d = PH_BIT_WAIT;
			PH_BIT_WAIT: begin
				if (level && !prev_q) begin
					phase_d = PH_BIT_HIGH;
					tick_d  = TIMER_WIDTH'(1);
				end
			end
			PH_BIT_HIGH: begin
				if (level) begin
					tick_d = tick_inc;
				end else begin
					tick_d = '0;
					if (bits_dec == 6'd0) begin
						publish = 1'b1;
						phase_d = PH_INTERVAL;
						bits_d  = FRAME_BITS;
						shift_d = '0;
					end else begin
						phase_d = PH_BIT_WAIT;
						bits_d  = bits_dec;
						shift_d = shift_in;
					end
				end
			end
			default: begin
				phase_d = PH_INTERVAL;
				tick_d  = '0;
				bits_d  = FRAME_BITS;
				shift_d = '0;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			pub_d[k] = publish ? shift_in[32-8*k +: 8] : pub_q[k];
		end
		flag_d  = publish ? mismatch : flag_q;
		total_d = (publish && mismatch && total_q != 16'hFFFF) ? total_q + 16'd1 : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INTERVAL;
			tick_q  <= '0;
			prev_q  <= 1'b1;
			bits_q  <= FRAME_BITS;
			shift_q <= '0;
			for (int k = 0; k < 5; k++) pub_q[k] <= '0;
			flag_q  <= 1'b0;
			total_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			prev_q  <= level;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			for (int k = 0; k < 5; k++) pub_q[k] <= pub_d[k];
			flag_q  <= flag_d;
			total_q <= total_d;
		end
	end

	assign res.drive_low         = phase_q == PH_START;
	assign res.frame_valid       = publish;
	assign res.humidity_whole    = pub_d[0];
	assign res.humidity_frac     = pub_d[1];
	assign res.temperature_whole = pub_d[2];
	assign res.temperature_frac  = pub_d[3];
	assign res.received_sum      = pub_d[4];
	assign res.sum_mismatch      = flag_d;
	assign res.mismatch_count    = total_d;

endmodule

[design/humidity_sensor_single_wire_reader.sv]
// Top level of the single-wire humidity and temperature sensor reader
// Usage:
//   Input channel (in_valid, in_stall, line_level): one beat per microsecond tick
//   carrying the sampled data line. Output channel (out_valid, out_stall, fields):
//   exactly one result beat for every input beat, in order.
//   drive_low in a result beat tells the pad to pull the line low for that tick;
//   frame_valid marks the beat on which a new 40-bit frame is published.
//   The input register holds each accepted beat, then the result register holds
//   its result. Throughput: one beat per cycle, sustained while out_stall is low.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
//   next edge; write only while idle. Indexes outside the register list are ignored.
//   Reset: phase goes to the interval wait, bit count to 40, other counters and
//   published bytes clear, registers get their defaults; both channels come up empty.
//   Stall: while out_stall holds a result, one more beat is taken into the input
//   register, then in_stall rises until the result drains.
`timescale 1ns / 1ps
module humidity_sensor_single_wire_reader #(
	parameter int TIMER_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              line_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              drive_low,
	output logic                              frame_valid,
	output logic [7:0]                        humidity_whole,
	output logic [7:0]                        humidity_frac,
	output logic [7:0]                        temperature_whole,
	output logic [7:0]                        temperature_frac,
	output logic [7:0]                        received_sum,
	output logic                              sum_mismatch,
	output logic [15:0]                       mismatch_count,
	input  logic                              cfg_write,
	input  logic [hsswr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsswr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hsswr_pkg::*;
	`include "humidity_sensor_single_wire_reader_macros.svh"

	cfg_t    cfg;
	result_t res;
	result_t out_q;
	logic    valid_s1, level_s1;
	logic    out_valid_q;
	logic    out_free, step, accept;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	hsswr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsswr_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign drive_low         = out_q.drive_low;
	assign frame_valid       = out_q.frame_valid;
	assign humidity_whole    = out_q.humidity_whole;
	assign humidity_frac     = out_q.humidity_frac;
	assign temperature_whole = out_q.temperature_whole;
	assign temperature_frac  = out_q.temperature_frac;
	assign received_sum      = out_q.received_sum;
	assign sum_mismatch      = out_q.sum_mismatch;
	assign mismatch_count    = out_q.mismatch_count;

	`HSSWR_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, in_stall, valid_s1 && out_valid && out_stall)
	`HSSWR_ASSERT_NEXT(a_step_gives_beat, clk, arst_n, step, out_valid)
	`HSSWR_ASSERT_IMPL(a_no_frame_while_driving, clk, arst_n, out_valid && drive_low, !frame_valid)

endmodule
